>>> sv/assert_macros.svh
// Assertion macros shared by the mixer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

>>> sv/mvsm_pkg.sv
// Types and constants of the multi-voice sample mixer
`default_nettype none
package mvsm_pkg;
    localparam int KIND_W   = 3;
    localparam int VSEL_W   = 4;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int RATE_W   = 16;
    localparam int VOL_W    = 8;
    localparam int PITCH_W  = 16;
    localparam int MIX_W    = 15;
    localparam int CHOSEN_W = 3;
    localparam int MASK_W   = 8;
    localparam int STEP_W   = 24;
    localparam int PHASE_W  = 16;
    localparam int VVOL_W   = 7;
    localparam int DIVD_W   = 32;
    localparam int SRC_RATE = 11025;
    localparam logic [VVOL_W-1:0] VOL_MAX = 7'd64;

    localparam logic [KIND_W-1:0] K_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] K_START  = 3'd1;
    localparam logic [KIND_W-1:0] K_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] K_STOP   = 3'd3;
    localparam logic [KIND_W-1:0] K_TICK   = 3'd4;

    typedef enum logic [1:0] {DIV_ADDR, DIV_RATE, DIV_PITCH} t_div_sel;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VSEL_W-1:0]  voice;
        logic [ADDR_W-1:0]  sample_address;
        logic [BYTE_W-1:0]  sample_byte;
        logic [LEN_W-1:0]   sound_length;
        logic [RATE_W-1:0]  sound_rate;
        logic [VOL_W-1:0]   volume;
        logic [PITCH_W-1:0] pitch;
    } t_word;

    typedef struct packed {
        logic signed [MIX_W-1:0] mixed_sample;
        logic [CHOSEN_W-1:0]     chosen_voice;
        logic                    accepted;
        logic [MASK_W-1:0]       playing_mask;
    } t_result;

    typedef struct packed {
        logic     capture;
        logic     div_go;
        t_div_sel div_sel;
        logic     mem_wr;
        logic     start;
        logic     update;
        logic     stop;
        logic     tick_clr;
        logic     rd;
        logic     acc;
        logic     put;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              start_ok;
        logic              update_ok;
        logic              pitch_nz;
        logic              div_done;
        logic              last;
        logic              out_full;
    } t_stat;
endpackage
`default_nettype wire

>>> sv/mvsm_if.sv
// Input and result channel interfaces of the mixer
`default_nettype none
interface mvsm_in_if import mvsm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VSEL_W-1:0]  voice;
    logic [ADDR_W-1:0]  sample_address;
    logic [BYTE_W-1:0]  sample_byte;
    logic [LEN_W-1:0]   sound_length;
    logic [RATE_W-1:0]  sound_rate;
    logic [VOL_W-1:0]   volume;
    logic [PITCH_W-1:0] pitch;
    modport source (output valid, kind, voice, sample_address, sample_byte, sound_length,
                    sound_rate, volume, pitch, input ready);
    modport sink   (input valid, kind, voice, sample_address, sample_byte, sound_length,
                    sound_rate, volume, pitch, output ready);
endinterface

interface mvsm_out_if import mvsm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mixed_sample;
    logic [CHOSEN_W-1:0]     chosen_voice;
    logic                    accepted;
    logic [MASK_W-1:0]       playing_mask;
    modport source (output valid, mixed_sample, chosen_voice, accepted, playing_mask,
                    input ready);
    modport sink   (input valid, mixed_sample, chosen_voice, accepted, playing_mask,
                    output ready);
endinterface
`default_nettype wire

>>> sv/mvsm_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module mvsm_div import mvsm_pkg::*; #(
    parameter int DW = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DW-1:0]     i_divisor,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quot
);
    localparam int CW = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIVD_W-1:0] r_quot;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_dvs;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;
    logic              w_last;

    assign w_trial = {r_rem, r_quot[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_last  = r_cnt == CW'(DIVD_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quot <= {r_quot[DIVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> sv/mvsm_dp.sv
// Mixer datapath: voice state, sample memory, divider and output register
`default_nettype none
module mvsm_dp import mvsm_pkg::*; #(
    parameter int NUM_VOICES   = 8,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int OUTPUT_RATE  = 16000
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_word i_word,
    input  wire logic  i_out_ready,
    output t_stat      o_stat,
    output t_result    o_res,
    output logic       o_out_valid
);
    localparam int VW        = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1;
    localparam int AW        = $clog2(SAMPLE_DEPTH);
    localparam int AW1       = AW + 1;
    localparam int DW        = 8;
    localparam int ACC_W     = $clog2(NUM_VOICES) + 10;
    localparam int BASE_STEP = (SRC_RATE * 65536) / OUTPUT_RATE;
    localparam int BASE_DIVD = BASE_STEP * 256;
    localparam logic [63:0] AQ_FULL = ((64'd1 << 36) + 64'(SAMPLE_DEPTH) - 64'd1) /
                                      64'(SAMPLE_DEPTH);
    localparam logic [63:0] RQ_FULL = ((64'd1 << 48) + 64'(OUTPUT_RATE) - 64'd1) /
                                      64'(OUTPUT_RATE);
    localparam logic [28:0] AQ_MUL  = AQ_FULL[28:0];
    localparam logic [35:0] RQ_MUL  = RQ_FULL[35:0];

    t_word                   r_word;
    logic [NUM_VOICES-1:0]   r_active;
    logic [AW-1:0]           r_addr  [NUM_VOICES];
    logic [LEN_W-1:0]        r_len   [NUM_VOICES];
    logic [LEN_W-1:0]        r_pos   [NUM_VOICES];
    logic [PHASE_W-1:0]      r_phase [NUM_VOICES];
    logic [STEP_W-1:0]       r_step  [NUM_VOICES];
    logic [VVOL_W-1:0]       r_vol   [NUM_VOICES];
    logic [BYTE_W-1:0]       r_mem   [SAMPLE_DEPTH];
    logic [BYTE_W-1:0]       r_rdata;
    logic [AW-1:0]           r_amod;
    logic [8:0]              r_aq;
    logic                    r_cdone;
    logic [STEP_W-1:0]       r_stepq;
    logic [VW-1:0]           r_idx;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_ok;
    logic [VW-1:0]           r_chosen;
    logic                    r_out_valid;
    t_result                 r_res;

    logic                    w_vsel_ok;
    logic [VW-1:0]           w_vidx;
    logic [VW-1:0]           w_pref;
    logic [VW-1:0]           w_slot;
    logic [VVOL_W-1:0]       w_vscale;
    logic [44:0]             w_aprod;
    logic [31:0]             w_arem;
    logic [51:0]             w_rprod;
    logic                    w_div_go;
    logic [DW-1:0]           w_dvs;
    logic                    w_done;
    logic [DIVD_W-1:0]       w_quot;
    logic [STEP_W-1:0]       w_qsat;
    logic signed [8:0]       w_s9;
    logic signed [16:0]      w_prod;
    logic signed [16:0]      w_term;
    logic [24:0]             w_psum;
    logic [8:0]              w_carry;
    logic [16:0]             w_npos;
    logic                    w_end;
    logic [AW1-1:0]          w_nadr_raw;
    logic [AW-1:0]           w_nadr;
    logic signed [7:0]       w_sat;
    logic [7:0]              w_mag;
    logic [19:0]             w_mq;
    logic [6:0]              w_q;
    logic signed [6:0]       w_qs;
    logic [MASK_W-1:0]       w_mask;

    assign w_vsel_ok = {1'b0, r_word.voice} < 5'(NUM_VOICES);
    assign w_vidx    = r_word.voice[VW-1:0];
    assign w_pref    = w_vsel_ok ? w_vidx : '0;
    assign w_vscale  = r_word.volume[7:1] > VOL_MAX ? VOL_MAX : r_word.volume[7:1];

    always_comb begin
        w_slot = w_pref;
        if (r_active[w_pref]) begin
            w_slot = VW'(NUM_VOICES - 1);
            for (int i = NUM_VOICES - 1; i >= 0; i--) begin
                if (!r_active[i]) begin
                    w_slot = VW'(i);
                end
            end
        end
    end

    assign w_aprod = 45'(r_word.sample_address) * 45'(AQ_MUL);
    assign w_arem  = 32'(r_word.sample_address) - 32'(r_aq) * 32'(SAMPLE_DEPTH);
    assign w_rprod = 52'(r_word.sound_rate) * 52'(RQ_MUL);

    assign w_div_go = i_cmd.div_go && (i_cmd.div_sel == DIV_PITCH);
    assign w_dvs    = (r_word.pitch[15:8] == 8'd0) ? DW'(1) : DW'(r_word.pitch[15:8]);

    mvsm_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_div_go),
        .i_dividend (DIVD_W'(BASE_DIVD)),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    assign w_qsat = (|w_quot[DIVD_W-1:STEP_W]) ? '1 : w_quot[STEP_W-1:0];

    assign w_s9       = $signed({1'b0, r_rdata}) - 9'sd128;
    assign w_prod     = 17'(w_s9) * 17'($signed({1'b0, r_vol[r_idx]}));
    assign w_term     = w_prod >>> 6;
    assign w_psum     = 25'(r_phase[r_idx]) + 25'(r_step[r_idx]);
    assign w_carry    = w_psum[24:16];
    assign w_npos     = 17'(r_pos[r_idx]) + 17'(w_carry);
    assign w_end      = w_npos >= 17'(r_len[r_idx]);
    assign w_nadr_raw = AW1'(r_addr[r_idx]) + AW1'(w_carry);
    assign w_nadr     = (w_nadr_raw >= AW1'(SAMPLE_DEPTH)) ?
                        AW'(w_nadr_raw - AW1'(SAMPLE_DEPTH)) : w_nadr_raw[AW-1:0];

    assign w_sat  = (r_acc > ACC_W'(127)) ? 8'sd127 :
                    (r_acc < -ACC_W'(128)) ? -8'sd128 : r_acc[7:0];
    assign w_mag  = w_sat[7] ? 8'(-w_sat) : 8'(w_sat);
    assign w_mq   = 20'(w_mag) * 20'd3415;
    assign w_q    = w_mq[19:13];
    assign w_qs   = w_sat[7] ? -$signed(w_q) : $signed(w_q);
    assign w_mask = MASK_W'(r_active);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_amod] <= r_word.sample_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_addr[r_idx]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_cdone     <= 1'b0;
        end else begin
            r_cdone <= i_cmd.div_go && (i_cmd.div_sel != DIV_PITCH);
            if (i_cmd.start) begin
                r_active[w_slot] <= 1'b1;
            end
            if (i_cmd.stop && w_vsel_ok) begin
                r_active[w_vidx] <= 1'b0;
            end
            if (i_cmd.tick_clr) begin
                r_idx <= '0;
            end
            if (i_cmd.acc) begin
                if (r_active[r_idx] && w_end) begin
                    r_active[r_idx] <= 1'b0;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word   <= i_word;
            r_acc    <= '0;
            r_ok     <= 1'b0;
            r_chosen <= '0;
        end
        if (i_cmd.div_go && i_cmd.div_sel == DIV_ADDR) begin
            r_aq <= w_aprod[44:36];
        end
        if (i_cmd.div_go && i_cmd.div_sel == DIV_RATE) begin
            r_stepq <= STEP_W'(w_rprod[51:32]);
        end
        if (r_cdone && i_cmd.div_sel == DIV_ADDR) begin
            r_amod <= w_arem[AW-1:0];
        end
        if (w_done) begin
            r_stepq <= w_qsat;
        end
        if (i_cmd.start) begin
            r_addr[w_slot]  <= r_amod;
            r_len[w_slot]   <= r_word.sound_length;
            r_pos[w_slot]   <= '0;
            r_phase[w_slot] <= '0;
            r_step[w_slot]  <= r_stepq;
            r_vol[w_slot]   <= w_vscale;
            r_ok            <= 1'b1;
            r_chosen        <= w_slot;
        end
        if (i_cmd.update) begin
            r_vol[w_vidx]  <= w_vscale;
            r_step[w_vidx] <= (r_word.pitch != '0) ? r_stepq : STEP_W'(BASE_STEP);
            r_ok           <= 1'b1;
        end
        if (i_cmd.acc && r_active[r_idx]) begin
            r_acc          <= r_acc + ACC_W'(w_term);
            r_phase[r_idx] <= w_psum[15:0];
            r_pos[r_idx]   <= w_end ? '0 : w_npos[15:0];
            r_addr[r_idx]  <= w_nadr;
        end
        if (i_cmd.put) begin
            r_res.mixed_sample <= {w_qs, 8'b0};
            r_res.chosen_voice <= CHOSEN_W'(r_chosen);
            r_res.accepted     <= r_ok;
            r_res.playing_mask <= w_mask;
        end
    end

    assign o_stat.kind      = r_word.kind;
    assign o_stat.start_ok  = (r_word.sound_length != '0) && (r_word.sound_rate != '0);
    assign o_stat.update_ok = w_vsel_ok && r_active[w_vidx];
    assign o_stat.pitch_nz  = r_word.pitch != '0;
    assign o_stat.div_done  = w_done || r_cdone;
    assign o_stat.last      = r_idx == VW'(NUM_VOICES - 1);
    assign o_stat.out_full  = r_out_valid && !i_out_ready;
    assign o_res            = r_res;
    assign o_out_valid      = r_out_valid;
endmodule
`default_nettype wire

>>> sv/mvsm_ctrl.sv
// Mixer controller state machine
`default_nettype none
module mvsm_ctrl import mvsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_ready
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_GO_A, S_WT_A, S_GO_R, S_WT_R, S_GO_P, S_WT_P,
        S_WRITE, S_START, S_UPD, S_RD, S_ACC, S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_GO_R, S_WT_R: o_cmd.div_sel = DIV_RATE;
            S_GO_P, S_WT_P: o_cmd.div_sel = DIV_PITCH;
            default:        o_cmd.div_sel = DIV_ADDR;
        endcase
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.kind)
                    K_LOAD:   n_state = S_GO_A;
                    K_START:  n_state = i_stat.start_ok ? S_GO_A : S_PUT;
                    K_UPDATE: begin
                        if (!i_stat.update_ok) begin
                            n_state = S_PUT;
                        end else if (i_stat.pitch_nz) begin
                            n_state = S_GO_P;
                        end else begin
                            n_state = S_UPD;
                        end
                    end
                    K_STOP: begin
                        o_cmd.stop = 1'b1;
                        n_state    = S_PUT;
                    end
                    K_TICK: begin
                        o_cmd.tick_clr = 1'b1;
                        n_state        = S_RD;
                    end
                    default: n_state = S_PUT;
                endcase
            end
            S_GO_A: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_WT_A;
            end
            S_WT_A: begin
                if (i_stat.div_done) begin
                    n_state = (i_stat.kind == K_LOAD) ? S_WRITE : S_GO_R;
                end
            end
            S_GO_R: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_WT_R;
            end
            S_WT_R: begin
                if (i_stat.div_done) begin
                    n_state = S_START;
                end
            end
            S_GO_P: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_WT_P;
            end
            S_WT_P: begin
                if (i_stat.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_PUT;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_PUT;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_PUT;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last ? S_PUT : S_RD;
            end
            S_PUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> sv/multi_voice_sample_mixer_top.sv
// One word at a time: a new word is accepted only after the previous result has
// been registered and the controller is idle again. Only a pitch update runs the
// restoring divider; tick walks the voices with one sample memory read each.
// Synchronous active-low reset idles all voices; the sample memory is not cleared.
`default_nettype none
`include "assert_macros.svh"
module multi_voice_sample_mixer_top import mvsm_pkg::*; #(
    parameter int NUM_VOICES   = 8,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int OUTPUT_RATE  = 16000
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mvsm_in_if.sink    i_in,
    mvsm_out_if.source o_out
);
    t_cmd    w_cmd;
    t_stat   w_stat;
    t_word   w_word;
    t_result w_res;
    logic    w_ready;
    logic    w_out_valid;

    always_comb begin
        w_word.kind           = i_in.kind;
        w_word.voice          = i_in.voice;
        w_word.sample_address = i_in.sample_address;
        w_word.sample_byte    = i_in.sample_byte;
        w_word.sound_length   = i_in.sound_length;
        w_word.sound_rate     = i_in.sound_rate;
        w_word.volume         = i_in.volume;
        w_word.pitch          = i_in.pitch;
    end

    mvsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_ready)
    );

    mvsm_dp #(
        .NUM_VOICES   (NUM_VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .OUTPUT_RATE  (OUTPUT_RATE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_word      (w_word),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_out_valid (w_out_valid)
    );

    assign i_in.ready         = w_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.mixed_sample = w_res.mixed_sample;
    assign o_out.chosen_voice = w_res.chosen_voice;
    assign o_out.accepted     = w_res.accepted;
    assign o_out.playing_mask = w_res.playing_mask;

    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_IMP(a_tick_not_accepted, i_clk, i_rst_n, o_out.valid && o_out.accepted,
                o_out.mixed_sample == 15'sd0)
    `ASSERT_IMP(a_chosen_needs_accept, i_clk, i_rst_n,
                o_out.valid && o_out.chosen_voice != 3'd0, o_out.accepted)
endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the eight-voice sample playback mixer
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import mvsm_pkg::*;

    localparam int VOICES     = 8;
    localparam int MEM_DEPTH  = 65536;
    localparam int MIX_RATE   = 16000;
    localparam int BASE_STEP  = (SRC_RATE << 16) / MIX_RATE;
    localparam int STEP_LIMIT = 24'hFFFFFF;
    localparam int HOLD_LEN   = 400;
    localparam int WORD_W     = $bits(t_word);
    localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    mvsm_in_if  in_ch ();
    mvsm_out_if out_ch ();

    multi_voice_sample_mixer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // mixer state as predicted
    logic [7:0]  mem_byte   [MEM_DEPTH];
    bit          mem_loaded [MEM_DEPTH];
    bit          v_active   [VOICES];
    logic [15:0] v_start    [VOICES];
    logic [15:0] v_length   [VOICES];
    logic [15:0] v_pos      [VOICES];
    logic [15:0] v_phase    [VOICES];
    logic [23:0] v_step     [VOICES];
    logic [6:0]  v_vol      [VOICES];

    t_result expected_mix_q [$];
    int      fail_count;
    bit      tx_gaps;
    bit      rx_stalls;
    bit      hold_req;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [6:0] halve_volume(logic [7:0] vol);
        return (vol >> 1) > VOL_MAX ? VOL_MAX : 7'(vol >> 1);
    endfunction

    function automatic logic [7:0] playing_now();
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < VOICES; i++) m[i] = v_active[i];
        return m;
    endfunction

    function automatic t_result mix_word(t_word w);
        t_result r;
        int      slot;
        int      acc;
        int      p;
        int      d;
        int      res;
        longint  st;
        logic [31:0] psum;
        logic [31:0] npos;
        r = '0;
        case (w.kind)
            K_LOAD: begin
                mem_byte[w.sample_address]   = w.sample_byte;
                mem_loaded[w.sample_address] = 1'b1;
            end
            K_START: begin
                if (w.sound_length != 0 && w.sound_rate != 0) begin
                    slot = w.voice < VOICES ? int'(w.voice) : 0;
                    for (int i = 0; i < VOICES && v_active[slot]; i++) begin
                        slot = i;
                        if (!v_active[i]) break;
                    end
                    v_active[slot] = 1'b1;
                    v_start[slot]  = w.sample_address;
                    v_length[slot] = w.sound_length;
                    v_pos[slot]    = '0;
                    v_phase[slot]  = '0;
                    st = (longint'(w.sound_rate) << 16) / MIX_RATE;
                    v_step[slot]   = st > STEP_LIMIT ? STEP_LIMIT : 24'(st);
                    v_vol[slot]    = halve_volume(w.volume);
                    r.chosen_voice = 3'(slot);
                    r.accepted     = 1'b1;
                end
            end
            K_UPDATE: begin
                if (w.voice < VOICES && v_active[w.voice]) begin
                    v_vol[w.voice] = halve_volume(w.volume);
                    if (w.pitch != 0) begin
                        d  = w.pitch >> 8;
                        if (d == 0) d = 1;
                        st = longint'(BASE_STEP) * 256 / d;
                        v_step[w.voice] = st > STEP_LIMIT ? STEP_LIMIT : 24'(st);
                    end else begin
                        v_step[w.voice] = 24'(BASE_STEP);
                    end
                    r.accepted = 1'b1;
                end
            end
            K_STOP: begin
                if (w.voice < VOICES) v_active[w.voice] = 1'b0;
            end
            K_TICK: begin
                acc = 0;
                for (int i = 0; i < VOICES; i++) begin
                    if (!v_active[i]) continue;
                    p = (int'(mem_byte[16'(v_start[i] + v_pos[i])]) - 128) * int'(v_vol[i]);
                    acc += p >= 0 ? p / 64 : -((-p + 63) / 64);
                    psum = 32'(v_phase[i]) + 32'(v_step[i]);
                    npos = 32'(v_pos[i]) + (psum >> 16);
                    v_phase[i] = psum[15:0];
                    if (npos >= 32'(v_length[i])) begin
                        v_active[i] = 1'b0;
                        v_pos[i]    = '0;
                    end else begin
                        v_pos[i] = npos[15:0];
                    end
                end
                if (acc > 127) acc = 127;
                if (acc < -128) acc = -128;
                res = (acc * 5 / 12) * 256;
                r.mixed_sample = res[MIX_W-1:0];
            end
            default: ;
        endcase
        r.playing_mask = playing_now();
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_word(t_word w);
        int gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= w.kind;
        in_ch.voice          <= w.voice;
        in_ch.sample_address <= w.sample_address;
        in_ch.sample_byte    <= w.sample_byte;
        in_ch.sound_length   <= w.sound_length;
        in_ch.sound_rate     <= w.sound_rate;
        in_ch.volume         <= w.volume;
        in_ch.pitch          <= w.pitch;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_mix_q.push_back(mix_word(w));
    endtask

    function automatic t_word blank_word(logic [KIND_W-1:0] k);
        t_word w;
        w      = '0;
        w.kind = k;
        return w;
    endfunction

    task automatic load_byte(logic [15:0] a, logic [7:0] b);
        t_word w;
        w = blank_word(K_LOAD);
        w.sample_address = a;
        w.sample_byte    = b;
        send_word(w);
    endtask

    task automatic start_voice(logic [3:0] v, logic [15:0] a, logic [15:0] len,
                               logic [15:0] rate, logic [7:0] vol);
        t_word w;
        w = blank_word(K_START);
        w.voice          = v;
        w.sample_address = a;
        w.sound_length   = len;
        w.sound_rate     = rate;
        w.volume         = vol;
        send_word(w);
    endtask

    task automatic update_voice(logic [3:0] v, logic [7:0] vol, logic [15:0] pitch);
        t_word w;
        w = blank_word(K_UPDATE);
        w.voice  = v;
        w.volume = vol;
        w.pitch  = pitch;
        send_word(w);
    endtask

    task automatic stop_voice(logic [3:0] v);
        t_word w;
        w = blank_word(K_STOP);
        w.voice = v;
        send_word(w);
    endtask

    // stop any voice that would read a byte never loaded
    task automatic tick(t_word w = blank_word(K_TICK));
        for (int i = 0; i < VOICES; i++)
            if (v_active[i] && !mem_loaded[16'(v_start[i] + v_pos[i])])
                stop_voice(4'(i));
        w.kind = K_TICK;
        send_word(w);
    endtask

    task automatic test_fill_window();
        for (int a = 0; a < 32; a++) load_byte(16'(a), 8'($urandom));
        for (int a = MEM_DEPTH - 8; a < MEM_DEPTH; a++) load_byte(16'(a), 8'($urandom));
    endtask

    task automatic test_directed();
        tick();
        load_byte(16'd0, 8'd255);
        load_byte(16'hFFFF, 8'd0);
        start_voice(4'd2, 16'd1, 16'd0, 16'd8000, 8'd100);
        start_voice(4'd2, 16'd1, 16'd10, 16'd0, 8'd100);
        start_voice(4'd15, 16'd0, 16'd20, 16'd65535, 8'd255);
        start_voice(4'd0, 16'hFFFE, 16'd6, 16'd1, 8'd0);
        start_voice(4'd9, 16'd4, 16'd16, 16'd11025, 8'd254);
        for (int v = 3; v < VOICES; v++)
            start_voice(4'(v), 16'(v), 16'd20, 16'd16000, 8'd128);
        start_voice(4'd5, 16'd2, 16'd65535, 16'd44100, 8'd255);
        update_voice(4'd12, 8'd50, 16'd512);
        update_voice(4'd1, 8'd255, 16'd0);
        update_voice(4'd3, 8'd1, 16'd255);
        update_voice(4'd4, 8'd200, 16'd65535);
        stop_voice(4'd15);
        stop_voice(4'd6);
        send_word(blank_word(K_SPARE_LO));
        send_word(blank_word(K_SPARE_HI));
        repeat (4) tick();
    endtask

    function automatic t_word random_word();
        t_word w;
        int    pick;
        w    = t_word'(WORD_W'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            w.kind = K_LOAD;
            if ($urandom_range(0, 3) != 0) w.sample_address = 16'($urandom_range(0, 47));
        end else if (pick < 37) begin
            w.kind = K_START;
            if ($urandom_range(0, 4) != 0) w.sample_address = 16'($urandom_range(0, 40));
            if ($urandom_range(0, 4) != 0) w.sound_length = 16'($urandom_range(1, 40));
            if ($urandom_range(0, 3) != 0) w.sound_rate = 16'($urandom_range(2000, 48000));
            if ($urandom_range(0, 19) == 0) w.sound_length = '0;
            if ($urandom_range(0, 19) == 0) w.sound_rate = '0;
        end else if (pick < 47) begin
            w.kind = K_UPDATE;
            if ($urandom_range(0, 3) != 0) w.voice[3] = 1'b0;
            if ($urandom_range(0, 9) == 0) w.pitch = '0;
        end else if (pick < 52) begin
            w.kind = K_STOP;
        end else if (pick < 96) begin
            w.kind = K_TICK;
        end else begin
            w.kind = 3'($urandom_range(K_SPARE_LO, K_SPARE_HI));
        end
        return w;
    endfunction

    task automatic test_back_pressure();
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        start_voice(4'd0, 16'd0, 16'd30, 16'd16000, 8'd128);
        repeat (10) tick();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random(int n);
        t_word w;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            if (i == n / 2) begin
                tx_gaps   = 1'b1;
                rx_stalls = 1'b1;
            end
            w = random_word();
            if (w.kind == K_TICK) tick(w);
            else send_word(w);
        end
    endtask

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_stalls && $urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_mix_q.size() == 0) begin
                $display("%0t unexpected word: mixed %0d chosen %0d accepted %0b mask %b",
                         $time, out_ch.mixed_sample, out_ch.chosen_voice,
                         out_ch.accepted, out_ch.playing_mask);
                fail_count++;
            end else begin
                want = expected_mix_q.pop_front();
                if (out_ch.mixed_sample !== want.mixed_sample) begin
                    $display("%0t mixed_sample expected %0d actual %0d",
                             $time, want.mixed_sample, out_ch.mixed_sample);
                    fail_count++;
                end
                if (out_ch.chosen_voice !== want.chosen_voice) begin
                    $display("%0t chosen_voice expected %0d actual %0d",
                             $time, want.chosen_voice, out_ch.chosen_voice);
                    fail_count++;
                end
                if (out_ch.accepted !== want.accepted) begin
                    $display("%0t accepted expected %0b actual %0b",
                             $time, want.accepted, out_ch.accepted);
                    fail_count++;
                end
                if (out_ch.playing_mask !== want.playing_mask) begin
                    $display("%0t playing_mask expected %b actual %b",
                             $time, want.playing_mask, out_ch.playing_mask);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int drain;
        fail_count = 0;
        tx_gaps    = 1'b1;
        rx_stalls  = 1'b1;
        hold_req   = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
            v_active[i] = 1'b0;
            v_start[i]  = '0;
            v_length[i] = '0;
            v_pos[i]    = '0;
            v_phase[i]  = '0;
            v_step[i]   = 24'(BASE_STEP);
            v_vol[i]    = '0;
        end
        in_ch.valid          = 1'b0;
        in_ch.kind           = '0;
        in_ch.voice          = '0;
        in_ch.sample_address = '0;
        in_ch.sample_byte    = '0;
        in_ch.sound_length   = '0;
        in_ch.sound_rate     = '0;
        in_ch.volume         = '0;
        in_ch.pitch          = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_window();
        test_directed();
        test_back_pressure();
        test_random(850);
        in_ch.valid <= 1'b0;
        drain = 0;
        while (expected_mix_q.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && expected_mix_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
